FILE: sv/dcma_pkg.sv
// shared types and constants of the dual channel moving average
package dcma_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int WINDOW_DEFAULT = 10;

    typedef struct packed {
        logic [SAMPLE_W-1:0] second;
        logic [SAMPLE_W-1:0] first;
    } sample_pair_t;

    localparam int PAIR_W = $bits(sample_pair_t);

endpackage

FILE: sv/dcma_window_ram.sv
// window store holding one sample pair per slot, registered read
module dcma_window_ram
    import dcma_pkg::*;
#(
    parameter int DEPTH  = WINDOW_DEFAULT,
    parameter int ADDR_W = 4
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  sample_pair_t      wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output sample_pair_t      rd_data
);

    sample_pair_t mem [DEPTH];
    sample_pair_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/dcma_divider.sv
// restoring divider, one quotient bit per cycle, shared by both channels
module dcma_divider
    import dcma_pkg::*;
#(
    parameter int SUM_W = 20,
    parameter int CNT_W = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [SUM_W-1:0]    dividend,
    input  logic [CNT_W-1:0]    divisor,
    output logic                done,
    output logic [SAMPLE_W-1:0] quotient
);

    localparam int STEP_W = $clog2(SUM_W);

    logic               busy_reg;
    logic               done_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [SUM_W-1:0]   quot_reg;
    logic [CNT_W-1:0]   rem_reg;
    logic [CNT_W-1:0]   divisor_reg;

    logic [CNT_W:0]     trial;
    logic [CNT_W:0]     diff;
    logic               fits;
    logic [CNT_W-1:0]   rem_next;
    logic [SUM_W-1:0]   quot_next;

    always_comb begin
        trial     = {rem_reg, quot_reg[SUM_W-1]};
        diff      = trial - {1'b0, divisor_reg};
        fits      = (trial >= {1'b0, divisor_reg});
        rem_next  = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        quot_next = {quot_reg[SUM_W-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end else if (busy_reg) begin
            // last quotient bit goes in on the final step
            if (step_reg == STEP_W'(SUM_W - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quot_reg    <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
            step_reg    <= '0;
        end else if (busy_reg) begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
            step_reg <= step_reg + 1'b1;
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg[SAMPLE_W-1:0];

endmodule

FILE: sv/dual_channel_moving_average.sv
// two-channel moving average over the last WINDOW valid samples, with warm-up
//
// input channel s_*: one sensor poll per item. s_tuser carries the status flags,
// s_tdata the two 16-bit channel samples. a poll with the ready flag set and the
// invalid flag clear enters both windows and yields one result item; any other
// poll is taken and yields nothing.
// result channel m_*: the truncated mean of each channel's stored samples,
// divided by the number stored so far during warm-up and by WINDOW after.
// sequence: after a valid poll the running sums update in the update state, then one
// shared restoring divider runs twice, once per channel, at one quotient bit
// per cycle over SUM_W = 16 + clog2(WINDOW+1) bits. the result is registered
// for m_* after the second division, and the block is ready again the cycle
// after the result is taken, so a new poll is accepted only once the last
// result has left. s_tready is low while an item is in work.
// if the receiver stalls, the result holds in the output register and no new
// poll is accepted until it is taken.
// reset clears the windows' fill count, write slot and sums; no clearing pass.
module dual_channel_moving_average
    import dcma_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [2*SAMPLE_W-1:0] s_tdata,  // first_sample, second_sample
    input  logic [1:0]            s_tuser,  // ready_flag, invalid_flag
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [2*SAMPLE_W-1:0] m_tdata   // first_average, second_average
);

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SUM_W  = SAMPLE_W + CNT_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_UPDATE = 3'd1;
    localparam logic [2:0] ST_DIV1   = 3'd2;
    localparam logic [2:0] ST_DIV2   = 3'd3;
    localparam logic [2:0] ST_OUT    = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic [SUM_W-1:0]    first_sum_reg, first_sum_next;
    logic [SUM_W-1:0]    second_sum_reg, second_sum_next;
    sample_pair_t        smp_reg;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [SAMPLE_W-1:0] first_avg_reg, second_avg_reg;

    logic                in_accept;
    logic                poll_good;
    logic                full;
    sample_pair_t        old_pair;
    logic                ram_wr_en;
    logic                ram_rd_en;
    logic                div_start;
    logic [SUM_W-1:0]    div_dividend;
    logic                div_done;
    logic [SAMPLE_W-1:0] div_quotient;

    assign in_accept = s_tvalid && s_tready;
    assign poll_good = s_tuser[0] && !s_tuser[1];
    assign full      = (fill_reg == CNT_W'(WINDOW));
    assign ram_rd_en = in_accept && poll_good;
    assign ram_wr_en = (state_reg == ST_UPDATE);

    dcma_window_ram #(
        .DEPTH  (WINDOW),
        .ADDR_W (SLOT_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (slot_reg),
        .wr_data (smp_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (slot_reg),
        .rd_data (old_pair)
    );

    dcma_divider #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (fill_next),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb begin
        state_next      = state_reg;
        slot_next       = slot_reg;
        fill_next       = fill_reg;
        first_sum_next  = first_sum_reg;
        second_sum_next = second_sum_reg;
        m_tvalid_next   = m_tvalid_reg;
        div_start       = 1'b0;
        div_dividend    = second_sum_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_accept && poll_good) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                // oldest sample leaves the sum once the window is full
                first_sum_next  = first_sum_reg
                                - (full ? SUM_W'(old_pair.first) : SUM_W'(0))
                                + SUM_W'(smp_reg.first);
                second_sum_next = second_sum_reg
                                - (full ? SUM_W'(old_pair.second) : SUM_W'(0))
                                + SUM_W'(smp_reg.second);
                fill_next       = full ? fill_reg : fill_reg + 1'b1;
                slot_next       = (slot_reg == SLOT_W'(WINDOW - 1)) ? '0
                                                                    : slot_reg + 1'b1;
                div_dividend    = first_sum_next;
                div_start       = 1'b1;
                state_next      = ST_DIV1;
            end
            ST_DIV1: begin
                if (div_done) begin
                    div_start  = 1'b1;
                    state_next = ST_DIV2;
                end
            end
            ST_DIV2: begin
                if (div_done) begin
                    m_tvalid_next = 1'b1;
                    state_next    = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_tready) begin
                    m_tvalid_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next    = ST_IDLE;
                m_tvalid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            slot_reg       <= '0;
            fill_reg       <= '0;
            first_sum_reg  <= '0;
            second_sum_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            slot_reg       <= slot_next;
            fill_reg       <= fill_next;
            first_sum_reg  <= first_sum_next;
            second_sum_reg <= second_sum_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            smp_reg <= s_tdata;
        end
        if (state_reg == ST_DIV1 && div_done) begin
            first_avg_reg <= div_quotient;
        end
        if (state_reg == ST_DIV2 && div_done) begin
            second_avg_reg <= div_quotient;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {second_avg_reg, first_avg_reg};

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(WINDOW))
        else $error("fill count beyond window");

    a_slot_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        slot_reg <= SLOT_W'(WINDOW - 1))
        else $error("write slot beyond window");

    a_good_poll: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && poll_good) |=> (state_reg == ST_UPDATE))
        else $error("valid poll did not start an update");

    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV1 || state_reg == ST_DIV2))
        else $error("divider finished outside a divide step");

endmodule
